// ===== rtl/ae2_pkg.sv =====
// Shared widths, stage map, register indexes and pipeline types for the two-stage auto-exposure step.
`default_nettype none
package ae2_pkg;

    localparam int EXP_W   = 24;
    localparam int GAIN_W  = 16;
    localparam int LUMA_W  = 16;
    localparam int FRAC_W  = 16;
    localparam int FAC_W   = FRAC_W + 1;
    localparam int VAL_W   = (EXP_W > GAIN_W) ? EXP_W : GAIN_W;
    localparam int CFG_W   = (VAL_W > LUMA_W) ? VAL_W : LUMA_W;
    localparam int CIDX_W  = 3;

    localparam logic [LUMA_W-1:0] LUMA_VALID_MAX = LUMA_W'(65280);
    localparam logic [FAC_W-1:0]  FAC_ONE        = FAC_W'(1) << FRAC_W;

    // divider: one quotient bit per step, several steps per stage
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = FRAC_W / DIV_STEPS;

    // stage map
    localparam int ST_IN  = 0;
    localparam int ST_SEL = ST_IN + DIV_STAGES + 1;
    localparam int ST_MUL = ST_SEL + 1;
    localparam int ST_RND = ST_MUL + 1;
    localparam int ST_OUT = ST_RND + 1;
    localparam int NST    = ST_OUT + 1;

    localparam logic [LUMA_W-1:0] RST_TARGET    = LUMA_W'(30720);
    localparam logic [LUMA_W-1:0] RST_DEAD_BAND = LUMA_W'(1024);
    localparam logic [FRAC_W-1:0] RST_MAX_STEP  = FRAC_W'(16384);
    localparam logic [EXP_W-1:0]  RST_EXP_FLOOR = EXP_W'(1);
    localparam logic [EXP_W-1:0]  RST_EXP_CEIL  = EXP_W'(10000);
    localparam logic [GAIN_W-1:0] RST_GAIN_FLOOR = GAIN_W'(1);
    localparam logic [GAIN_W-1:0] RST_GAIN_CEIL  = GAIN_W'(1024);

    typedef enum logic [CIDX_W-1:0] {
        CFG_TARGET    = 3'd0,
        CFG_DEAD_BAND = 3'd1,
        CFG_MAX_STEP  = 3'd2,
        CFG_EXP_FLOOR = 3'd3,
        CFG_EXP_CEIL  = 3'd4,
        CFG_GAIN_FLOOR = 3'd5,
        CFG_GAIN_CEIL = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [LUMA_W-1:0] rem;
        logic [FRAC_W-1:0] quo;
    } t_div;

    typedef struct packed {
        logic [EXP_W-1:0]  exp_in;
        logic [GAIN_W-1:0] gain_in;
        logic [EXP_W-1:0]  exp_c;
        logic [GAIN_W-1:0] gain_c;
        logic              up;
        logic              active;
        logic              sat;
        logic              sel_exp;
    } t_ctx;

endpackage
`default_nettype wire

// ===== rtl/ae2_div_step.sv =====
// Restoring divider slice: several quotient bits of error * 2^16 / target.
`default_nettype none
module ae2_div_step (
    input  wire ae2_pkg::t_div                 i_div,
    input  wire logic [ae2_pkg::LUMA_W-1:0]    i_divisor,
    output ae2_pkg::t_div                      o_div
);

    always_comb begin
        logic [ae2_pkg::LUMA_W:0]   rem2;
        logic [ae2_pkg::LUMA_W-1:0] rem;
        logic [ae2_pkg::FRAC_W-1:0] quo;
        rem = i_div.rem;
        quo = i_div.quo;
        for (int s = 0; s < ae2_pkg::DIV_STEPS; s++) begin
            rem2 = {rem, 1'b0};
            if (rem2 >= {1'b0, i_divisor}) begin
                rem2 = rem2 - {1'b0, i_divisor};
                quo  = {quo[ae2_pkg::FRAC_W-2:0], 1'b1};
            end else begin
                quo  = {quo[ae2_pkg::FRAC_W-2:0], 1'b0};
            end
            rem = rem2[ae2_pkg::LUMA_W-1:0];
        end
        o_div.rem = rem;
        o_div.quo = quo;
    end

endmodule
`default_nettype wire

// ===== rtl/two_stage_auto_exposure_step.sv =====
// Top level: pipelined two-stage AE step; exposure rises first, gain falls first.
//
// Input word (i_valid/o_ready): current exposure, current gain and frame mean
// luma in Q8.8. Output word (o_valid/i_ready): next exposure, next gain and a
// changed flag, one output word per input word, in order.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data), no
// wait states; write only while the pipeline is empty.
// Throughput: one word per cycle while i_ready is high; nine register stages
// (input clamp, four radix-16 divider stages for error / target, step select,
// multiply, round and clamp, output).
// Every stage has its own valid bit and takes a new word whenever it is empty
// or its successor moves, so bubbles close up while the receiver stalls and
// the input keeps accepting until all stages are full. A stall holds the
// output word steady; nothing is dropped or repeated.
// Reset (synchronous, active low) empties the pipeline and restores the
// register defaults; o_ready is high in the first cycle after reset.
`default_nettype none
module two_stage_auto_exposure_step (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [ae2_pkg::EXP_W-1:0]     i_exposure_now,
    input  wire logic [ae2_pkg::GAIN_W-1:0]    i_gain_now,
    input  wire logic [ae2_pkg::LUMA_W-1:0]    i_mean_luma,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [ae2_pkg::EXP_W-1:0]          o_exposure_next,
    output logic [ae2_pkg::GAIN_W-1:0]         o_gain_next,
    output logic                               o_changed,
    input  wire logic                          i_cfg_we,
    input  wire logic [ae2_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  wire logic [ae2_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int VW = ae2_pkg::VAL_W;
    localparam int PW = ae2_pkg::VAL_W + ae2_pkg::FAC_W;

    // v < lo gives lo, else v > hi gives hi
    function automatic logic [VW-1:0] f_clamp(input logic [VW+1:0] v,
                                              input logic [VW-1:0] lo,
                                              input logic [VW-1:0] hi);
        logic [VW-1:0] res;
        if (v < {2'b00, lo}) begin
            res = lo;
        end else if (v > {2'b00, hi}) begin
            res = hi;
        end else begin
            res = v[VW-1:0];
        end
        return res;
    endfunction

    // configuration registers
    logic [ae2_pkg::LUMA_W-1:0] r_target, r_dead_band;
    logic [ae2_pkg::FRAC_W-1:0] r_max_step;
    logic [ae2_pkg::EXP_W-1:0]  r_exp_floor, r_exp_ceil;
    logic [ae2_pkg::GAIN_W-1:0] r_gain_floor, r_gain_ceil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= ae2_pkg::RST_TARGET;
            r_dead_band  <= ae2_pkg::RST_DEAD_BAND;
            r_max_step   <= ae2_pkg::RST_MAX_STEP;
            r_exp_floor  <= ae2_pkg::RST_EXP_FLOOR;
            r_exp_ceil   <= ae2_pkg::RST_EXP_CEIL;
            r_gain_floor <= ae2_pkg::RST_GAIN_FLOOR;
            r_gain_ceil  <= ae2_pkg::RST_GAIN_CEIL;
        end else if (i_cfg_we) begin
            case (ae2_pkg::t_cfg_idx'(i_cfg_idx))
                ae2_pkg::CFG_TARGET:     r_target     <= i_cfg_data[ae2_pkg::LUMA_W-1:0];
                ae2_pkg::CFG_DEAD_BAND:  r_dead_band  <= i_cfg_data[ae2_pkg::LUMA_W-1:0];
                ae2_pkg::CFG_MAX_STEP:   r_max_step   <= i_cfg_data[ae2_pkg::FRAC_W-1:0];
                ae2_pkg::CFG_EXP_FLOOR:  r_exp_floor  <= i_cfg_data[ae2_pkg::EXP_W-1:0];
                ae2_pkg::CFG_EXP_CEIL:   r_exp_ceil   <= i_cfg_data[ae2_pkg::EXP_W-1:0];
                ae2_pkg::CFG_GAIN_FLOOR: r_gain_floor <= i_cfg_data[ae2_pkg::GAIN_W-1:0];
                ae2_pkg::CFG_GAIN_CEIL:  r_gain_ceil  <= i_cfg_data[ae2_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic [ae2_pkg::NST-1:0] r_v;
    logic [ae2_pkg::NST-1:0] w_rdy;
    logic [ae2_pkg::NST-1:0] w_vsrc;
    logic [ae2_pkg::NST-1:0] w_ld;

    always_comb begin
        w_rdy[ae2_pkg::NST-1] = !r_v[ae2_pkg::NST-1] || i_ready;
        for (int k = ae2_pkg::NST - 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
        w_vsrc[0] = i_valid;
        for (int k = 1; k < ae2_pkg::NST; k++) begin
            w_vsrc[k] = r_v[k-1];
        end
        w_ld = w_rdy & w_vsrc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < ae2_pkg::NST; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= w_vsrc[k];
                end
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[ae2_pkg::ST_OUT];

    // context travelling with each word
    ae2_pkg::t_ctx r_ctx [ae2_pkg::NST];
    ae2_pkg::t_ctx w_ctx_src [ae2_pkg::NST];
    ae2_pkg::t_ctx w_ctx_in;
    ae2_pkg::t_ctx w_ctx_sel;

    // input stage: clamp, error magnitude, dead band
    logic [ae2_pkg::LUMA_W-1:0] w_mag;
    ae2_pkg::t_div              w_div_in;

    always_comb begin
        w_ctx_in.exp_in  = i_exposure_now;
        w_ctx_in.gain_in = i_gain_now;
        w_ctx_in.exp_c   = ae2_pkg::EXP_W'(f_clamp(
            (VW+2)'(i_exposure_now), VW'(r_exp_floor), VW'(r_exp_ceil)));
        w_ctx_in.gain_c  = ae2_pkg::GAIN_W'(f_clamp(
            (VW+2)'(i_gain_now), VW'(r_gain_floor), VW'(r_gain_ceil)));
        w_ctx_in.up      = r_target > i_mean_luma;
        w_mag            = w_ctx_in.up ? (r_target - i_mean_luma)
                                       : (i_mean_luma - r_target);
        w_ctx_in.active  = (i_mean_luma <= ae2_pkg::LUMA_VALID_MAX) &&
                           (w_mag > r_dead_band);
        w_ctx_in.sat     = w_mag >= r_target;
        w_ctx_in.sel_exp = 1'b0;
        w_div_in.rem     = w_mag;
        w_div_in.quo     = '0;
    end

    // divider stages
    ae2_pkg::t_div r_div [ae2_pkg::DIV_STAGES+1];
    ae2_pkg::t_div w_div [ae2_pkg::DIV_STAGES+1];

    assign w_div[0] = w_div_in;

    for (genvar g = 1; g <= ae2_pkg::DIV_STAGES; g++) begin : g_div
        ae2_div_step u_step (
            .i_div     (r_div[g-1]),
            .i_divisor (r_target),
            .o_div     (w_div[g])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= ae2_pkg::DIV_STAGES; k++) begin
            if (w_ld[ae2_pkg::ST_IN + k]) begin
                r_div[k] <= w_div[k];
            end
        end
    end

    // step select: fraction, factor, operand
    localparam int DQ = ae2_pkg::ST_SEL - 1;
    logic [ae2_pkg::FRAC_W-1:0] w_fm;
    logic [ae2_pkg::FAC_W-1:0]  w_fac;
    logic [VW-1:0]              w_val, w_lo, w_hi;

    always_comb begin
        w_ctx_sel = r_ctx[DQ];
        if (r_ctx[DQ].sat || r_div[ae2_pkg::DIV_STAGES].quo > r_max_step) begin
            w_fm = r_max_step;
        end else begin
            w_fm = r_div[ae2_pkg::DIV_STAGES].quo;
        end
        w_fac = r_ctx[DQ].up ? (ae2_pkg::FAC_ONE + ae2_pkg::FAC_W'(w_fm))
                             : (ae2_pkg::FAC_ONE - ae2_pkg::FAC_W'(w_fm));
        if (r_ctx[DQ].up) begin
            w_ctx_sel.sel_exp = r_ctx[DQ].exp_c < r_exp_ceil;
        end else begin
            w_ctx_sel.sel_exp = !(r_ctx[DQ].gain_c > r_gain_floor);
        end
        w_val = w_ctx_sel.sel_exp ? VW'(r_ctx[DQ].exp_c) : VW'(r_ctx[DQ].gain_c);
        w_lo  = w_ctx_sel.sel_exp ? VW'(r_exp_floor) : VW'(r_gain_floor);
        w_hi  = w_ctx_sel.sel_exp ? VW'(r_exp_ceil) : VW'(r_gain_ceil);
    end

    always_comb begin
        w_ctx_src[0] = w_ctx_in;
        for (int k = 1; k < ae2_pkg::NST; k++) begin
            w_ctx_src[k] = (k == ae2_pkg::ST_SEL) ? w_ctx_sel : r_ctx[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ae2_pkg::NST; k++) begin
            if (w_ld[k]) begin
                r_ctx[k] <= w_ctx_src[k];
            end
        end
    end

    logic [VW-1:0]              r_val5, r_lo5, r_hi5;
    logic [ae2_pkg::FAC_W-1:0]  r_fac5;

    always_ff @(posedge i_clk) begin
        if (w_ld[ae2_pkg::ST_SEL]) begin
            r_val5 <= w_val;
            r_lo5  <= w_lo;
            r_hi5  <= w_hi;
            r_fac5 <= w_fac;
        end
    end

    // multiply
    logic [PW-1:0] r_prod6;
    logic [VW-1:0] r_val6, r_lo6, r_hi6;

    always_ff @(posedge i_clk) begin
        if (w_ld[ae2_pkg::ST_MUL]) begin
            r_prod6 <= PW'(r_val5) * PW'(r_fac5);
            r_val6  <= r_val5;
            r_lo6   <= r_lo5;
            r_hi6   <= r_hi5;
        end
    end

    // round half up, clamp, one-count fallback
    logic [PW:0]   w_sum;
    logic [VW-1:0] w_cand, w_alt;

    always_comb begin
        w_sum  = {1'b0, r_prod6} + (PW+1)'(1 << (ae2_pkg::FRAC_W - 1));
        w_cand = f_clamp((VW+2)'(w_sum[PW:ae2_pkg::FRAC_W]), r_lo6, r_hi6);
        if (r_ctx[ae2_pkg::ST_MUL].up) begin
            w_alt = f_clamp((VW+2)'(r_val6) + (VW+2)'(1), r_lo6, r_hi6);
        end else if (r_val6 == '0) begin
            w_alt = r_lo6;
        end else begin
            w_alt = f_clamp((VW+2)'(r_val6) - (VW+2)'(1), r_lo6, r_hi6);
        end
    end

    logic [VW-1:0] r_cand7, r_alt7;
    logic          r_eq7;

    always_ff @(posedge i_clk) begin
        if (w_ld[ae2_pkg::ST_RND]) begin
            r_cand7 <= w_cand;
            r_alt7  <= w_alt;
            r_eq7   <= w_cand == r_val6;
        end
    end

    // output register
    logic [VW-1:0]              w_nxt;
    logic [ae2_pkg::EXP_W-1:0]  w_exp_o;
    logic [ae2_pkg::GAIN_W-1:0] w_gain_o;
    ae2_pkg::t_ctx              w_c7;

    always_comb begin
        w_c7     = r_ctx[ae2_pkg::ST_RND];
        w_nxt    = r_eq7 ? r_alt7 : r_cand7;
        w_exp_o  = w_c7.exp_c;
        w_gain_o = w_c7.gain_c;
        if (w_c7.active) begin
            if (w_c7.sel_exp) begin
                w_exp_o = ae2_pkg::EXP_W'(w_nxt);
            end else begin
                w_gain_o = ae2_pkg::GAIN_W'(w_nxt);
            end
        end
    end

    logic [ae2_pkg::EXP_W-1:0]  r_exp_o;
    logic [ae2_pkg::GAIN_W-1:0] r_gain_o;
    logic                       r_chg_o;

    always_ff @(posedge i_clk) begin
        if (w_ld[ae2_pkg::ST_OUT]) begin
            r_exp_o  <= w_exp_o;
            r_gain_o <= w_gain_o;
            r_chg_o  <= (w_exp_o != w_c7.exp_in) || (w_gain_o != w_c7.gain_in);
        end
    end

    assign o_exposure_next = r_exp_o;
    assign o_gain_next     = r_gain_o;
    assign o_changed       = r_chg_o;

    // checks
    a_exp_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_exp_floor <= r_exp_ceil) |->
            (o_exposure_next >= r_exp_floor) && (o_exposure_next <= r_exp_ceil))
        else $error("exposure outside limits");

    a_gain_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_gain_floor <= r_gain_ceil) |->
            (o_gain_next >= r_gain_floor) && (o_gain_next <= r_gain_ceil))
        else $error("gain outside limits");

    a_one_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_exposure_next == r_ctx[ae2_pkg::ST_OUT].exp_c) ||
                    (o_gain_next == r_ctx[ae2_pkg::ST_OUT].gain_c))
        else $error("exposure and gain both stepped");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid straight after reset");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the two-stage auto-exposure step: bursty driver, stalling monitor, predictor.
`default_nettype none
module tb_top;
    import ae2_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_SETTING = 110;

    typedef struct {
        logic [EXP_W-1:0]  exposure;
        logic [GAIN_W-1:0] gain;
        logic [LUMA_W-1:0] luma;
    } frame_t;

    typedef struct {
        logic [EXP_W-1:0]  exposure;
        logic [GAIN_W-1:0] gain;
        logic              changed;
    } settings_t;

    typedef struct {
        logic [LUMA_W-1:0] target;
        logic [LUMA_W-1:0] dead_band;
        logic [FRAC_W-1:0] max_step;
        logic [EXP_W-1:0]  exp_floor;
        logic [EXP_W-1:0]  exp_ceil;
        logic [GAIN_W-1:0] gain_floor;
        logic [GAIN_W-1:0] gain_ceil;
    } limits_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [EXP_W-1:0]    in_exposure = '0;
    logic [GAIN_W-1:0]   in_gain = '0;
    logic [LUMA_W-1:0]   in_luma = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [EXP_W-1:0]    out_exposure;
    logic [GAIN_W-1:0]   out_gain;
    logic                out_changed;
    logic                cfg_we = 1'b0;
    logic [CIDX_W-1:0]   cfg_idx = '0;
    logic [CFG_W-1:0]    cfg_data = '0;

    // register copies used by the predictor
    limits_t lim = '{RST_TARGET, RST_DEAD_BAND, RST_MAX_STEP, RST_EXP_FLOOR,
                     RST_EXP_CEIL, RST_GAIN_FLOOR, RST_GAIN_CEIL};

    frame_t    frames_to_send[$];
    settings_t next_settings_due[$];

    int cycle_count = 0;
    int mismatch_count = 0;
    int frames_sent = 0;
    int results_checked = 0;
    int changed_seen = 0;
    int settings_used = 1;
    int gap_left = 0;
    int burst_left = 1;
    int stall_mode = 0;
    int stall_mode_left = 0;

    two_stage_auto_exposure_step DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_exposure_now  (in_exposure),
        .i_gain_now      (in_gain),
        .i_mean_luma     (in_luma),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_exposure_next (out_exposure),
        .o_gain_next     (out_gain),
        .o_changed       (out_changed),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial forever #5 clk = ~clk;

    function automatic longint limit_value(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint rescale(longint v, longint factor, bit dark,
                                       longint lo, longint hi);
        longint r;
        r = limit_value((v * factor + 32768) >> 16, lo, hi);
        if (r == v)
            r = limit_value(dark ? v + 1 : v - 1, lo, hi);
        return r;
    endfunction

    function automatic settings_t predict_next_settings(frame_t f);
        longint e_lo, e_hi, g_lo, g_hi, e_val, g_val;
        longint tgt, err, mag, ms, frac, factor;
        bit dark;
        settings_t r;
        e_lo = lim.exp_floor;
        e_hi = lim.exp_ceil;
        g_lo = lim.gain_floor;
        g_hi = lim.gain_ceil;
        tgt = lim.target;
        e_val = limit_value(longint'(f.exposure), e_lo, e_hi);
        g_val = limit_value(longint'(f.gain), g_lo, g_hi);
        err = tgt - longint'(f.luma);
        mag = (err < 0) ? -err : err;
        if (f.luma <= LUMA_VALID_MAX && mag > longint'(lim.dead_band)) begin
            ms = lim.max_step;
            dark = err > 0;
            if (tgt == 0) begin
                frac = dark ? ms : -ms;
            end else begin
                frac = (mag * 65536) / tgt;
                if (!dark)
                    frac = -frac;
            end
            if (frac > ms)
                frac = ms;
            if (frac < -ms)
                frac = -ms;
            factor = 65536 + frac;
            if (dark) begin
                if (e_val < e_hi)
                    e_val = rescale(e_val, factor, 1'b1, e_lo, e_hi);
                else
                    g_val = rescale(g_val, factor, 1'b1, g_lo, g_hi);
            end else begin
                if (g_val > g_lo)
                    g_val = rescale(g_val, factor, 1'b0, g_lo, g_hi);
                else
                    e_val = rescale(e_val, factor, 1'b0, e_lo, e_hi);
            end
        end
        r.exposure = e_val[EXP_W-1:0];
        r.gain = g_val[GAIN_W-1:0];
        r.changed = (e_val != longint'(f.exposure)) || (g_val != longint'(f.gain));
        return r;
    endfunction

    function automatic longint pick_span(longint a, longint b);
        longint lo, hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return lo + longint'($urandom_range(int'(hi - lo), 0));
    endfunction

    // biased towards the limits and small values, where the +1 step shows
    function automatic longint pick_level(longint lo, longint hi, int bits);
        case ($urandom_range(0, 11))
            0: return longint'($urandom) & ((longint'(1) << bits) - 1);
            1: return lo;
            2: return hi;
            3: return hi - 1;
            4: return lo + 1;
            5: return 0;
            6: return (longint'(1) << bits) - 1;
            7: return $urandom_range(0, 4);
            default: return pick_span(lo, hi);
        endcase
    endfunction

    function automatic frame_t make_frame();
        frame_t f;
        longint m, off;
        f.exposure = EXP_W'(pick_level(lim.exp_floor, lim.exp_ceil, EXP_W));
        f.gain = GAIN_W'(pick_level(lim.gain_floor, lim.gain_ceil, GAIN_W));
        case ($urandom_range(0, 9))
            0: m = $urandom_range(int'(LUMA_VALID_MAX) + 1, 65535);
            1: m = $urandom_range(0, 65535);
            2, 3: begin
                off = longint'(lim.dead_band) + $urandom_range(0, 3) - 1;
                m = $urandom_range(0, 1) ? longint'(lim.target) - off
                                         : longint'(lim.target) + off;
                m = limit_value(m, 0, 65535);
            end
            4: m = 0;
            5: m = LUMA_VALID_MAX;
            default: m = $urandom_range(0, int'(LUMA_VALID_MAX));
        endcase
        f.luma = LUMA_W'(m);
        return f;
    endfunction

    function automatic void queue_frame(longint e, longint g, longint m);
        frame_t f;
        f.exposure = EXP_W'(e);
        f.gain = GAIN_W'(g);
        f.luma = LUMA_W'(m);
        frames_to_send.push_back(f);
    endfunction

    task automatic wait_drained();
        while (frames_to_send.size() != 0 || in_valid || next_settings_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        case (idx)
            CFG_TARGET:     lim.target = value[LUMA_W-1:0];
            CFG_DEAD_BAND:  lim.dead_band = value[LUMA_W-1:0];
            CFG_MAX_STEP:   lim.max_step = value[FRAC_W-1:0];
            CFG_EXP_FLOOR:  lim.exp_floor = value[EXP_W-1:0];
            CFG_EXP_CEIL:   lim.exp_ceil = value[EXP_W-1:0];
            CFG_GAIN_FLOOR: lim.gain_floor = value[GAIN_W-1:0];
            CFG_GAIN_CEIL:  lim.gain_ceil = value[GAIN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_limits(limits_t s);
        wait_drained();
        write_register(CFG_TARGET, CFG_W'(s.target));
        write_register(CFG_DEAD_BAND, CFG_W'(s.dead_band));
        write_register(CFG_MAX_STEP, CFG_W'(s.max_step));
        write_register(CFG_EXP_FLOOR, CFG_W'(s.exp_floor));
        write_register(CFG_EXP_CEIL, CFG_W'(s.exp_ceil));
        write_register(CFG_GAIN_FLOOR, CFG_W'(s.gain_floor));
        write_register(CFG_GAIN_CEIL, CFG_W'(s.gain_ceil));
        settings_used++;
    endtask

    task automatic queue_random_frames(int n);
        repeat (n) frames_to_send.push_back(make_frame());
        wait_drained();
    endtask

    // sender: bursts of words separated by random gaps
    always @(posedge clk) begin
        frame_t f;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                f.exposure = in_exposure;
                f.gain = in_gain;
                f.luma = in_luma;
                next_settings_due.push_back(predict_next_settings(f));
                frames_sent++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left != 0 || frames_to_send.size() == 0) begin
                    in_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left--;
                end else begin
                    f = frames_to_send.pop_front();
                    in_exposure <= f.exposure;
                    in_gain <= f.gain;
                    in_luma <= f.luma;
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // receiver: checks each word, stalls in modes of random length
    always @(posedge clk) begin
        settings_t want;
        if (rst_n && out_valid && out_ready) begin
            if (next_settings_due.size() == 0) begin
                $error("unexpected word: exposure_next %0d gain_next %0d changed %0b",
                       out_exposure, out_gain, out_changed);
                mismatch_count++;
            end else begin
                want = next_settings_due.pop_front();
                results_checked++;
                if (out_changed === 1'b1)
                    changed_seen++;
                if (out_exposure !== want.exposure) begin
                    $error("exposure_next: expected %0d, got %0d", want.exposure, out_exposure);
                    mismatch_count++;
                end
                if (out_gain !== want.gain) begin
                    $error("gain_next: expected %0d, got %0d", want.gain, out_gain);
                    mismatch_count++;
                end
                if (out_changed !== want.changed) begin
                    $error("changed: expected %0b, got %0b", want.changed, out_changed);
                    mismatch_count++;
                end
            end
        end
        if (stall_mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(50, 300);
        end else begin
            stall_mode_left--;
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        limits_t s;
        int k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults: dead band edges, clamps, both stages, invalid mean
        queue_frame(5000, 100, 30720);
        queue_frame(5000, 100, 30720 - 1024);
        queue_frame(5000, 100, 30720 - 1025);
        queue_frame(5000, 100, 30720 + 1025);
        queue_frame(5000, 100, 0);
        queue_frame(10000, 100, 0);
        queue_frame(10000, 1024, 0);
        queue_frame(5000, 500, 65280);
        queue_frame(5000, 1, 65280);
        queue_frame(1, 1, 65280);
        queue_frame(20000, 100, 65281);
        queue_frame(0, 0, 65535);
        queue_frame(16777215, 65535, 30720);
        queue_frame(2, 100, 30720 - 1100);
        queue_frame(3, 1, 30720 + 1100);
        wait_drained();

        apply_limits('{30720, 1024, 16384, 1, 10000, 1, 1024});
        queue_random_frames(ITEMS_PER_SETTING);

        // widest limits, tiny target, step limit at maximum
        apply_limits('{1, 0, 65535, 0, 16777215, 0, 65535});
        queue_frame(0, 0, 65280);
        queue_frame(16777215, 65535, 65280);
        queue_random_frames(ITEMS_PER_SETTING);

        // zero step limit: every move is a single count
        apply_limits('{65280, 0, 0, 0, 16777215, 0, 65535});
        queue_random_frames(ITEMS_PER_SETTING);

        // dead band at maximum, floors equal ceilings
        apply_limits('{65535, 65535, 32768, 16777215, 16777215, 65535, 65535});
        queue_random_frames(ITEMS_PER_SETTING / 2);

        // zero target
        apply_limits('{0, 0, 8192, 100, 200, 10, 20});
        queue_frame(150, 10, 65280);
        queue_frame(150, 15, 0);
        queue_random_frames(ITEMS_PER_SETTING / 2);

        // floors above ceilings
        apply_limits('{40000, 256, 20000, 5000, 1000, 300, 100});
        queue_frame(500, 50, 0);
        queue_frame(3000, 200, 65280);
        queue_frame(7000, 400, 30000);
        queue_random_frames(ITEMS_PER_SETTING / 2);

        for (k = 0; k < 4; k++) begin
            s.target = $urandom_range(1, int'(LUMA_VALID_MAX));
            s.dead_band = $urandom_range(0, 3000);
            s.max_step = $urandom_range(0, 65535);
            s.exp_floor = $urandom_range(0, 50);
            s.exp_ceil = s.exp_floor + $urandom_range(0, 1 << $urandom_range(3, 20));
            s.gain_floor = $urandom_range(0, 20);
            s.gain_ceil = s.gain_floor + $urandom_range(0, 4000);
            apply_limits(s);
            queue_random_frames(ITEMS_PER_SETTING);
        end

        wait_drained();
        repeat (30) @(posedge clk);
        $display("Ran %0d frames under %0d register settings; %0d words checked, %0d changed.",
                 frames_sent, settings_used, results_checked, changed_seen);
        if (mismatch_count == 0 && next_settings_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire
